FILE: hdl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared widths, register indexes and types for the ray/box slab entry block.
// ----------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

  // Coordinate format: signed fixed point
  localparam int COORD_W  = 32;
  localparam int FRAC     = 16;
  localparam int AXES     = 3;
  localparam int LANES    = 2 * AXES;
  localparam int FIELDS   = 4 * AXES;
  localparam int IN_W     = FIELDS * COORD_W;

  // Quotient magnitude bits below the saturation point
  localparam int QW       = COORD_W - 1;
  // Numerator bits still fed into the divider after the first compare
  localparam int MNL_W    = QW - FRAC;
  localparam int NUM_W    = COORD_W + 1;

  // Divider pipeline: quotient bits per stage and stage count
  localparam int STEPS    = 4;
  localparam int DIV_STG  = (QW + STEPS - 1) / STEPS;

  // Result and configuration formats
  localparam int DIST_W   = 31;
  localparam int TOL_W    = 16;
  localparam int OUT_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_MAX_DIST = cfg_idx_t'(0);
  localparam cfg_idx_t REG_TOL      = cfg_idx_t'(1);

  localparam logic [DIST_W-1:0] MAX_DIST_RST = '1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0]        mag_t;

  // Per-axis flags that ride beside the divider lanes
  typedef struct packed {
    logic [AXES-1:0] zero;   // direction component is zero
    logic            zmiss;  // origin outside a parallel slab
  } axis_flags_t;

endpackage

`default_nettype wire

FILE: hdl/rbs_div_lane.sv
// ----------------------------------------------------------------------------
// rbs_div_lane
// Pipelined restoring divider for one slab distance: STEPS quotient bits per
// stage, saturated signed result at the last stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_div_lane (
  input  wire logic                          clk,
  input  wire logic [rbs_pkg::DIV_STG-1:0]   en,     // per-stage load enable
  input  wire rbs_pkg::mag_t                 rem_i,  // initial partial remainder
  input  wire rbs_pkg::mag_t                 md_i,   // divisor magnitude
  input  wire logic [rbs_pkg::MNL_W-1:0]     mnl_i,  // low numerator bits
  input  wire logic                          neg_i,
  input  wire logic                          ovf_i,
  output rbs_pkg::coord_t                    t_o
);
  import rbs_pkg::*;

  mag_t               r_r   [DIV_STG];
  logic [QW-1:0]      q_r   [DIV_STG];
  mag_t               md_r  [DIV_STG];
  logic [MNL_W-1:0]   mnl_r [DIV_STG];
  logic               neg_r [DIV_STG];
  logic               ovf_r [DIV_STG];

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    mag_t             r_in;
    mag_t             md_in;
    logic [QW-1:0]    q_in;
    logic [MNL_W-1:0] mnl_in;
    logic             neg_in;
    logic             ovf_in;
    mag_t             r_nxt;
    logic [QW-1:0]    q_nxt;
    logic [MNL_W-1:0] mnl_nxt;

    // Stage inputs: lane operands at the head, previous stage otherwise
    if (s == 0) begin : g_head
      assign r_in   = rem_i;
      assign q_in   = '0;
      assign mnl_in = mnl_i;
      assign md_in  = md_i;
      assign neg_in = neg_i;
      assign ovf_in = ovf_i;
    end else begin : g_body
      assign r_in   = r_r[s-1];
      assign q_in   = q_r[s-1];
      assign mnl_in = mnl_r[s-1];
      assign md_in  = md_r[s-1];
      assign neg_in = neg_r[s-1];
      assign ovf_in = ovf_r[s-1];
    end

    // Up to STEPS shift/compare/subtract steps (fewer in the last stage when QW is not a multiple)
    always_comb begin
      mag_t rs;
      rs      = '0;
      r_nxt   = r_in;
      q_nxt   = q_in;
      mnl_nxt = mnl_in;
      for (int j = 0; j < STEPS; j++) begin
        if (s * STEPS + j < QW) begin
          rs      = {r_nxt[COORD_W-2:0], mnl_nxt[MNL_W-1]};
          mnl_nxt = {mnl_nxt[MNL_W-2:0], 1'b0};
          if (rs >= md_in) begin
            r_nxt = rs - md_in;
            q_nxt = {q_nxt[QW-2:0], 1'b1};
          end else begin
            r_nxt = rs;
            q_nxt = {q_nxt[QW-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        r_r[s]   <= r_nxt;
        q_r[s]   <= q_nxt;
        mnl_r[s] <= mnl_nxt;
        md_r[s]  <= md_in;
        neg_r[s] <= neg_in;
        ovf_r[s] <= ovf_in;
      end
    end
  end

  // Sign and saturation
  always_comb begin
    if (ovf_r[DIV_STG-1]) begin
      t_o = neg_r[DIV_STG-1] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
    end else if (neg_r[DIV_STG-1]) begin
      t_o = -coord_t'({1'b0, q_r[DIV_STG-1]});
    end else begin
      t_o = coord_t'({1'b0, q_r[DIV_STG-1]});
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ray_box_slab_entry.sv
// ----------------------------------------------------------------------------
// ray_box_slab_entry
// Ray versus axis-aligned box slab test, fixed point, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload (low bit first)
// in_     | in  | origin_x,y,z, dir_x,y,z, box_lo_x,y,z, box_hi_x,y,z
// out_    | out | hit, entry_distance
// cfg_    | in  | cfg_index, cfg_data (0 max_distance, 1 tolerance)
//
// One item is taken every cycle unless the output stalls; six pipelined
// restoring dividers, at 4 quotient bits per divider stage, allow this.
// A stall holds each full stage with no empty stage after it; the rest keep filling.
// Reset clears valid bits and loads the configuration reset values.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_entry (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z
  input  wire logic [rbs_pkg::IN_W-1:0]       in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // hit [0], entry_distance [31:1]
  output logic [rbs_pkg::OUT_W-1:0]           out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire rbs_pkg::cfg_idx_t              cfg_index,
  input  wire logic [rbs_pkg::CFG_W-1:0]      cfg_data
);
  import rbs_pkg::*;

  // Configuration registers
  logic [DIST_W-1:0] maxd_r;
  logic [TOL_W-1:0]  tol_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxd_r <= MAX_DIST_RST;
      tol_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_DIST: maxd_r <= cfg_data[DIST_W-1:0];
        REG_TOL:      tol_r  <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables, from the output backwards
  logic               vp_r, ve_r, vf_r;
  logic [DIV_STG-1:0] vd_r;
  logic               en_o, en_f, en_e, en_p;
  logic [DIV_STG-1:0] en_d;

  assign en_o = !out_tvalid || out_tready;
  assign en_f = !vf_r || en_o;
  assign en_e = !ve_r || en_f;
  always_comb begin
    en_d[DIV_STG-1] = !vd_r[DIV_STG-1] || en_e;
    for (int k = DIV_STG - 2; k >= 0; k--) begin
      en_d[k] = !vd_r[k] || en_d[k+1];
    end
  end
  assign en_p      = !vp_r || en_d[0];
  assign in_tready = en_p;

  // Prep: slab numerators, magnitudes, overflow pre-check
  mag_t              rem_r [LANES];
  mag_t              md_r  [LANES];
  logic [MNL_W-1:0]  mnl_r [LANES];
  logic              neg_r [LANES];
  logic              ovf_r [LANES];
  axis_flags_t       flg_p_r;
  axis_flags_t       flg_p_nxt;
  logic [AXES-1:0]   zero_p;
  logic              zmiss_p;
  coord_t            t_w [LANES];

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    coord_t o, d, lo, hi;
    mag_t   md;
    assign o  = in_tdata[a*COORD_W +: COORD_W];
    assign d  = in_tdata[(AXES + a)*COORD_W +: COORD_W];
    assign lo = in_tdata[(2*AXES + a)*COORD_W +: COORD_W];
    assign hi = in_tdata[(3*AXES + a)*COORD_W +: COORD_W];
    assign md = d[COORD_W-1] ? mag_t'(-d) : mag_t'(d);

    assign zero_p[a] = (d == '0);

    for (genvar b = 0; b < 2; b++) begin : g_bnd
      logic signed [NUM_W-1:0] num;
      logic [NUM_W-1:0]        mn;
      assign num = (b == 0) ? (NUM_W'(lo) - NUM_W'(o)) : (NUM_W'(hi) - NUM_W'(o));
      assign mn  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

      always_ff @(posedge clk) begin
        if (en_p) begin
          rem_r[2*a+b] <= mag_t'(mn[NUM_W-1:MNL_W]);
          md_r[2*a+b]  <= md;
          mnl_r[2*a+b] <= mn[MNL_W-1:0];
          neg_r[2*a+b] <= num[NUM_W-1] ^ d[COORD_W-1];
          ovf_r[2*a+b] <= NUM_W'(mn[NUM_W-1:MNL_W]) >= NUM_W'(md);
        end
      end

      rbs_div_lane u_div (
        .clk   (clk),
        .en    (en_d),
        .rem_i (rem_r[2*a+b]),
        .md_i  (md_r[2*a+b]),
        .mnl_i (mnl_r[2*a+b]),
        .neg_i (neg_r[2*a+b]),
        .ovf_i (ovf_r[2*a+b]),
        .t_o   (t_w[2*a+b])
      );
    end
  end

  // Parallel slab rejects
  always_comb begin
    zmiss_p = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      if (zero_p[a] &&
          (($signed(in_tdata[a*COORD_W +: COORD_W]) <
            $signed(in_tdata[(2*AXES + a)*COORD_W +: COORD_W])) ||
           ($signed(in_tdata[a*COORD_W +: COORD_W]) >
            $signed(in_tdata[(3*AXES + a)*COORD_W +: COORD_W])))) begin
        zmiss_p = 1'b1;
      end
    end
  end

  assign flg_p_nxt = {zero_p, zmiss_p};

  always_ff @(posedge clk) begin
    if (en_p) flg_p_r <= flg_p_nxt;
  end

  // Flags and valid bits beside the divider stages
  axis_flags_t flg_d_r [DIV_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      vd_r <= '0;
    end else begin
      if (en_p) vp_r <= in_tvalid;
      if (en_d[0]) vd_r[0] <= vp_r;
      for (int k = 1; k < DIV_STG; k++) begin
        if (en_d[k]) vd_r[k] <= vd_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_d[0]) flg_d_r[0] <= flg_p_r;
    for (int k = 1; k < DIV_STG; k++) begin
      if (en_d[k]) flg_d_r[k] <= flg_d_r[k-1];
    end
  end

  // Near and far per axis
  coord_t      tn_r [AXES];
  coord_t      tf_r [AXES];
  axis_flags_t flg_e_r;

  always_ff @(posedge clk) begin
    if (en_e) begin
      flg_e_r <= flg_d_r[DIV_STG-1];
      for (int a = 0; a < AXES; a++) begin
        if (t_w[2*a] < t_w[2*a+1]) begin
          tn_r[a] <= t_w[2*a];
          tf_r[a] <= t_w[2*a+1];
        end else begin
          tn_r[a] <= t_w[2*a+1];
          tf_r[a] <= t_w[2*a];
        end
      end
    end
  end

  // Entry and exit over all axes
  coord_t tmin_r, tmax_r, tmin_nxt, tmax_nxt;
  logic   zmiss_f_r;

  always_comb begin
    tmin_nxt = '0;
    tmax_nxt = coord_t'({1'b0, maxd_r});
    for (int a = 0; a < AXES; a++) begin
      if (!flg_e_r.zero[a]) begin
        if (tn_r[a] > tmin_nxt) tmin_nxt = tn_r[a];
        if (tf_r[a] < tmax_nxt) tmax_nxt = tf_r[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      tmin_r    <= tmin_nxt;
      tmax_r    <= tmax_nxt;
      zmiss_f_r <= flg_e_r.zmiss;
    end
  end

  // Final range check and output register
  logic miss;
  assign miss = zmiss_f_r ||
                ($signed({tmin_r[COORD_W-1], tmin_r}) >
                 $signed({tmax_r[COORD_W-1], tmax_r}) + $signed({1'b0, 16'(0), tol_r})) ||
                (tmin_r > coord_t'({1'b0, maxd_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r       <= 1'b0;
      vf_r       <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      if (en_e) ve_r <= vd_r[DIV_STG-1];
      if (en_f) vf_r <= ve_r;
      if (en_o) out_tvalid <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      out_tdata <= miss ? '0 : {tmin_r[DIST_W-1:0], 1'b1};
    end
  end

  // Checks
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[OUT_W-1:1] == '0)
    else $error("miss result carries a nonzero distance");

  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[OUT_W-1:1] <= maxd_r)
    else $error("entry distance beyond max_distance");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && vd_r == '0)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
